>>> hdl/rotary_position_embedding_engine_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rotary position embedding engine
// Wraps concurrent assertions so that synthesis sees empty bodies.
// ----------------------------------------------------------------------------
`ifndef ROTARY_POSITION_EMBEDDING_ENGINE_MACROS_SVH
`define ROTARY_POSITION_EMBEDDING_ENGINE_MACROS_SVH

`ifndef SYNTHESIS
// Checked while reset is released.
`define ROPE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);
// Checked on every edge, reset included.
`define ROPE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ROPE_ASSERT(label, clk, rst_n, prop, msg)
`define ROPE_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

>>> hdl/rope_pkg.sv
// ----------------------------------------------------------------------------
// Rotary position embedding package
// Shared constants, codes and types of the rotary position embedding engine.
// ----------------------------------------------------------------------------
`default_nettype none

package rope_pkg;

    // Sizes of the datapath and of the held-operand store.
    localparam int MAX_HEAD   = 256;
    localparam int DATA_WIDTH = 16;
    localparam int COEF_WIDTH = 16;
    localparam int COEF_FRAC  = 14;
    localparam int HOLD_DEPTH = MAX_HEAD / 2;
    localparam int HOLD_AW    = $clog2(HOLD_DEPTH);
    localparam int CNT_W      = 9;
    localparam int DIMS_W     = 9;
    localparam int MODE_W     = 2;
    localparam int IDX_W      = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;
    localparam int PROD_W     = DATA_WIDTH + COEF_WIDTH;

    // Output queue.
    localparam int OQ_DEPTH = 8;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);

    // Pairing modes.
    localparam logic [MODE_W-1:0] MODE_HALF  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INTL  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MIXED = 2'd2;
    localparam logic [MODE_W-1:0] MODE_PASS  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PAIRING_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTARY_DIMS  = 1'd1;

    // Register reset values.
    localparam logic [MODE_W-1:0] MODE_RESET = MODE_HALF;
    localparam logic [DIMS_W-1:0] DIMS_RESET = 9'd64;

    // What an accepted item turns into.
    typedef enum logic [1:0] {
        KIND_HOLD,
        KIND_PASS,
        KIND_PAIR
    } t_kind;

    // One entry of the held-operand store.
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] value;
        logic signed [COEF_WIDTH-1:0] cosine;
        logic signed [COEF_WIDTH-1:0] sine;
    } t_held;

    localparam int HELD_W = $bits(t_held);

    // Job handed from the decode stage to the rotation datapath.
    typedef struct packed {
        t_kind                        kind;
        logic                         intl;
        logic                         mixed;
        logic signed [DATA_WIDTH-1:0] x;
        logic signed [COEF_WIDTH-1:0] ca;
        logic signed [COEF_WIDTH-1:0] cb;
        logic [IDX_W-1:0]             idx0;
        logic [IDX_W-1:0]             idx1;
        logic                         last;
    } t_job;

    // Store access issued with each accepted item.
    typedef struct packed {
        logic               wr_en;
        logic [HOLD_AW-1:0] wr_addr;
        t_held              wr_data;
        logic               rd_en;
        logic [HOLD_AW-1:0] rd_addr;
    } t_ram_req;

    // One result item.
    typedef struct packed {
        logic [IDX_W-1:0]             index;
        logic signed [DATA_WIDTH-1:0] value;
        logic                         last;
    } t_result;

    // Up to two results pushed into the output queue in one cycle.
    typedef struct packed {
        logic [1:0] n;
        t_result    r0;
        t_result    r1;
    } t_push;

endpackage

`default_nettype wire

>>> hdl/rope_in_if.sv
// ----------------------------------------------------------------------------
// Rotary position embedding input channel
// Valid/ready channel carrying one head vector element with its coefficients.
// ----------------------------------------------------------------------------
`default_nettype none

interface rope_in_if import rope_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] src_value;
    logic signed [COEF_WIDTH-1:0] coef_a;
    logic signed [COEF_WIDTH-1:0] coef_b;
    logic                         last_element;

    modport source (
        output valid, src_value, coef_a, coef_b, last_element,
        input  ready
    );
    modport sink (
        input  valid, src_value, coef_a, coef_b, last_element,
        output ready
    );
endinterface

`default_nettype wire

>>> hdl/rope_out_if.sv
// ----------------------------------------------------------------------------
// Rotary position embedding output channel
// Valid/ready channel carrying one result element with its position.
// ----------------------------------------------------------------------------
`default_nettype none

interface rope_out_if import rope_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic [IDX_W-1:0]             out_index;
    logic signed [DATA_WIDTH-1:0] out_value;
    logic                         out_last;

    modport source (
        output valid, out_index, out_value, out_last,
        input  ready
    );
    modport sink (
        input  valid, out_index, out_value, out_last,
        output ready
    );
endinterface

`default_nettype wire

>>> hdl/rotary_position_embedding_engine.sv
// ----------------------------------------------------------------------------
// Rotary position embedding engine
// Applies rotary position rotation to a stream of head vector elements.
//
// Usage:
//   Elements enter on i_src, one per item, with two coefficient words and a
//   last-element flag. Results leave on o_res with their element position.
//   Configuration (pairing mode, rotated length) is written on the i_cfg_*
//   port while no vector is in progress.
//   A result passes the job register, the product stage and the output
//   queue before its valid rises; the second result of a pair is queued
//   with the first and leaves after it.
//   Items are accepted one per cycle while the output queue has room and
//   items give at most one result; a pairing item gives two results, so
//   pairing items are held back by the single result port.
//   Held operands of each pair's first member live in one 128-entry
//   synchronous RAM, written at accept and read one item later at the
//   earliest, so no forwarding is needed.
//   Reset clears the element counter, the datapath valids and the 8-entry
//   output queue, and loads the register defaults; the RAM needs no clearing.
//   When o_res stalls, results collect in the output queue and i_src.ready
//   drops once the queue lacks room for two results per item in flight and two for the next item.
// ----------------------------------------------------------------------------
`default_nettype none

module rotary_position_embedding_engine import rope_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    rope_in_if.sink                    i_src,
    rope_out_if.source                 o_res
);

    logic              acc;
    logic              space;
    t_ram_req          ram_req;
    logic [HELD_W-1:0] held_data;
    logic              job_valid;
    t_job              job;
    logic              rot_busy;
    t_push             push;
    logic [1:0]        inflight;

    // Input handshake.
    assign i_src.ready = space;
    assign acc         = i_src.valid && space;

    // Decode and counter.
    rope_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_acc       (acc),
        .i_x         (i_src.src_value),
        .i_ca        (i_src.coef_a),
        .i_cb        (i_src.coef_b),
        .i_last      (i_src.last_element),
        .o_ram       (ram_req),
        .o_job_valid (job_valid),
        .o_job       (job)
    );

    // Held operands of the first member of each pair.
    rope_ram #(
        .WIDTH (HELD_W),
        .DEPTH (HOLD_DEPTH)
    ) u_held_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_req.wr_en),
        .i_wr_addr (ram_req.wr_addr),
        .i_wr_data (ram_req.wr_data),
        .i_rd_en   (ram_req.rd_en),
        .i_rd_addr (ram_req.rd_addr),
        .o_rd_data (held_data)
    );

    // Rotation datapath.
    rope_rot u_rot (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .i_held      (held_data),
        .o_busy      (rot_busy),
        .o_push      (push)
    );

    // Output queue with room reserved for items in flight.
    assign inflight = 2'(job_valid) + 2'(rot_busy);

    rope_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_inflight (inflight),
        .o_space    (space),
        .o_res      (o_res)
    );

endmodule

`default_nettype wire

>>> hdl/rope_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rope_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/rope_ctrl.sv
// ----------------------------------------------------------------------------
// Rotary position embedding decode stage
// Holds the configuration and element counter, classifies each item and
// issues the held-operand store write and read.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rotary_position_embedding_engine_macros.svh"

module rope_ctrl import rope_pkg::*; (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]        i_cfg_data,
    input  wire logic                         i_acc,
    input  wire logic signed [DATA_WIDTH-1:0] i_x,
    input  wire logic signed [COEF_WIDTH-1:0] i_ca,
    input  wire logic signed [COEF_WIDTH-1:0] i_cb,
    input  wire logic                         i_last,
    output t_ram_req                          o_ram,
    output logic                              o_job_valid,
    output t_job                              o_job
);

    localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'((1 << CNT_W) - 1);
    localparam logic [DIMS_W-1:0] DIMS_CAP = DIMS_W'(MAX_HEAD & ~1);

    logic [MODE_W-1:0] r_mode;
    logic [DIMS_W-1:0] r_dims;
    logic [CNT_W-1:0]  r_count;
    logic              r_job_valid;
    t_job              r_job;

    logic [DIMS_W-1:0] dims_even;
    logic [DIMS_W-1:0] rot_len;
    logic [CNT_W-1:0]  half_len;
    logic [CNT_W-1:0]  half_diff;
    logic              pass;
    logic              first;
    t_job              n_job;
    t_ram_req          req;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RESET;
            r_dims <= DIMS_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_PAIRING_MODE: r_mode <= i_cfg_data[MODE_W-1:0];
                CFG_ROTARY_DIMS:  r_dims <= i_cfg_data[DIMS_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective rotated length: even, capped at the store's reach.
    assign dims_even = {r_dims[DIMS_W-1:1], 1'b0};
    assign rot_len   = (dims_even > DIMS_CAP) ? DIMS_CAP : dims_even;
    assign half_len  = CNT_W'(rot_len[DIMS_W-1:1]);
    assign half_diff = r_count - half_len;

    // Classify the item and form the store access.
    always_comb begin
        pass  = (r_mode == MODE_PASS) || (CNT_W'(rot_len) <= r_count);
        first = 1'b0;
        req   = '0;

        n_job.intl  = (r_mode != MODE_HALF);
        n_job.mixed = (r_mode == MODE_MIXED);
        n_job.x     = i_x;
        n_job.ca    = i_ca;
        n_job.cb    = i_cb;
        n_job.idx1  = r_count[IDX_W-1:0];
        n_job.idx0  = r_count[IDX_W-1:0];
        n_job.last  = i_last;

        req.wr_data.value  = i_x;
        req.wr_data.cosine = i_ca;
        req.wr_data.sine   = (r_mode == MODE_MIXED) ? '0 : i_cb;

        if (r_mode == MODE_HALF) begin
            first       = (r_count < half_len);
            req.wr_addr = r_count[HOLD_AW-1:0];
            req.rd_addr = half_diff[HOLD_AW-1:0];
            n_job.idx0  = half_diff[IDX_W-1:0];
        end else begin
            first       = !r_count[0];
            req.wr_addr = r_count[HOLD_AW:1];
            req.rd_addr = r_count[HOLD_AW:1];
            n_job.idx0  = {r_count[IDX_W-1:1], 1'b0};
        end

        req.wr_en = i_acc && !pass && first;
        req.rd_en = i_acc;

        priority if (pass) begin
            n_job.kind = KIND_PASS;
        end else if (first) begin
            n_job.kind = i_last ? KIND_PASS : KIND_HOLD;
        end else begin
            n_job.kind = KIND_PAIR;
        end
    end

    // Element counter: clears after the last element, saturates at the top.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_acc) begin
            if (i_last) begin
                r_count <= '0;
            end else if (r_count != CNT_MAX) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // Job register, aligned with the store's read data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
        end else begin
            r_job_valid <= i_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_job <= n_job;
        end
    end

    assign o_ram       = req;
    assign o_job_valid = r_job_valid;
    assign o_job       = r_job;

    `ROPE_ASSERT(a_count_clears, i_clk, i_rst_n, i_acc && i_last |=> r_count == '0,
        "element counter did not clear after the last element")
    `ROPE_ASSERT(a_job_follows_accept, i_clk, i_rst_n, i_acc |=> r_job_valid,
        "accepted item did not reach the job register")

endmodule

`default_nettype wire

>>> hdl/rope_rot.sv
// ----------------------------------------------------------------------------
// Rotary position embedding rotation datapath
// Forms the four products from the job and the held operands, then sums,
// rounds and saturates them into up to two results.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rotary_position_embedding_engine_macros.svh"

module rope_rot import rope_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_job_valid,
    input  wire t_job              i_job,
    input  wire logic [HELD_W-1:0] i_held,
    output logic                   o_busy,
    output t_push                  o_push
);

    localparam int SW = PROD_W + 2;
    localparam logic signed [SW-1:0] RND    = SW'(1 << (COEF_FRAC - 1));
    localparam logic signed [SW-1:0] SAT_HI = SW'((1 << (DATA_WIDTH - 1)) - 1);
    localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

    t_held                        held;
    logic signed [COEF_WIDTH-1:0] coef_a0;
    logic signed [COEF_WIDTH-1:0] coef_b0;
    logic signed [COEF_WIDTH-1:0] coef_a1;
    logic signed [COEF_WIDTH-1:0] coef_b1;

    logic                     r_valid;
    t_job                     r_job;
    logic signed [PROD_W-1:0] r_m0;
    logic signed [PROD_W-1:0] r_m1;
    logic signed [PROD_W-1:0] r_m2;
    logic signed [PROD_W-1:0] r_m3;

    logic signed [SW-1:0]         sum0;
    logic signed [SW-1:0]         sum1;
    logic signed [DATA_WIDTH-1:0] res0;
    logic signed [DATA_WIDTH-1:0] res1;
    t_push                        push;

    function automatic logic signed [DATA_WIDTH-1:0] round_sat(
        input logic signed [SW-1:0] s
    );
        logic signed [SW-1:0] q;
        q = s >>> COEF_FRAC;
        if (q > SAT_HI) begin
            return SAT_HI[DATA_WIDTH-1:0];
        end else if (q < SAT_LO) begin
            return SAT_LO[DATA_WIDTH-1:0];
        end else begin
            return q[DATA_WIDTH-1:0];
        end
    endfunction

    // Coefficient selection. The first result is a0*x0 - b0*x and the second
    // is a1*x + b1*x0, where x0 is the held partner.
    assign held    = t_held'(i_held);
    assign coef_a0 = held.cosine;
    assign coef_b0 = i_job.mixed ? i_job.ca : held.sine;
    assign coef_a1 = i_job.intl ? held.cosine : i_job.ca;
    assign coef_b1 = i_job.intl ? coef_b0 : i_job.cb;

    // Product stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_job_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_job_valid) begin
            r_job <= i_job;
            r_m0  <= coef_a0 * held.value;
            r_m1  <= coef_b0 * i_job.x;
            r_m2  <= coef_a1 * i_job.x;
            r_m3  <= coef_b1 * held.value;
        end
    end

    // Sum, round to nearest and saturate.
    assign sum0 = SW'(r_m0) - SW'(r_m1) + RND;
    assign sum1 = SW'(r_m2) + SW'(r_m3) + RND;
    assign res0 = round_sat(sum0);
    assign res1 = round_sat(sum1);

    always_comb begin
        push          = '0;
        push.r0.index = r_job.idx1;
        push.r0.value = r_job.x;
        push.r0.last  = r_job.last;
        push.r1.index = r_job.idx1;
        push.r1.value = res1;
        push.r1.last  = r_job.last;
        unique case (r_job.kind)
            KIND_PASS: begin
                push.n = r_valid ? 2'd1 : 2'd0;
            end
            KIND_PAIR: begin
                push.n        = r_valid ? 2'd2 : 2'd0;
                push.r0.index = r_job.idx0;
                push.r0.value = res0;
                push.r0.last  = 1'b0;
            end
            default: begin
                push.n = 2'd0;
            end
        endcase
    end

    assign o_busy = r_valid;
    assign o_push = push;

    `ROPE_ASSERT(a_pair_order, i_clk, i_rst_n,
        push.n == 2'd2 |-> push.r0.index < push.r1.index && !push.r0.last,
        "pair results out of order or first result marked last")
    `ROPE_ASSERT(a_push_needs_job, i_clk, i_rst_n, push.n != 2'd0 |-> $past(i_job_valid),
        "result pushed without a job one cycle earlier")

endmodule

`default_nettype wire

>>> hdl/rope_outq.sv
// ----------------------------------------------------------------------------
// Rotary position embedding output queue
// Takes up to two results a cycle and hands them out one at a time; grants
// input only when room is reserved for every item still in the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rotary_position_embedding_engine_macros.svh"

module rope_outq import rope_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_push      i_push,
    input  wire logic [1:0] i_inflight,
    output logic            o_space,
    rope_out_if.source      o_res
);

    localparam int CW = OQ_AW + 2;

    t_result            r_mem [OQ_DEPTH];
    logic [OQ_AW-1:0]   r_head;
    logic [OQ_AW-1:0]   r_tail;
    logic [OQ_AW:0]     r_count;
    logic               pop;
    logic [OQ_AW-1:0]   tail_next;
    logic [CW-1:0]      reserved;

    assign pop       = o_res.valid && o_res.ready;
    assign tail_next = r_tail + 1'b1;

    // Each item in the datapath may still bring two results.
    assign reserved = CW'(r_count) + CW'({i_inflight, 1'b0});
    assign o_space  = (reserved <= CW'(OQ_DEPTH - 2));

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_mem[r_tail] <= i_push.r0;
        end
        if (i_push.n == 2'd2) begin
            r_mem[tail_next] <= i_push.r1;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_tail  <= r_tail + OQ_AW'(i_push.n);
            r_head  <= r_head + OQ_AW'(pop);
            r_count <= r_count + (OQ_AW + 1)'(i_push.n) - (OQ_AW + 1)'(pop);
        end
    end

    assign o_res.valid     = (r_count != '0);
    assign o_res.out_index = r_mem[r_head].index;
    assign o_res.out_value = r_mem[r_head].value;
    assign o_res.out_last  = r_mem[r_head].last;

    `ROPE_ASSERT(a_no_overflow, i_clk, i_rst_n,
        (CW'(r_count) + CW'(i_push.n)) <= CW'(OQ_DEPTH),
        "output queue overflow")
    `ROPE_ASSERT_ALWAYS(a_empty_after_reset, i_clk, !i_rst_n |=> !o_res.valid,
        "output valid after reset")

endmodule

`default_nettype wire
